// ===== design/jcs_pkg.sv =====
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared types and character constants for the comment stripper.
// ----------------------------------------------------------------------------
package jcs_pkg;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Output queue depth; a byte pushes at most two entries.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // One result as it travels to the output port.
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       run_last;
    logic       stream_end;
  } out_ent_t;

  // Everything one input byte releases.
  typedef struct packed {
    logic [1:0] n;
    out_ent_t   e0;
    out_ent_t   e1;
  } scan_res_t;

endpackage

// ===== design/jcs_scanner.sv =====
// ----------------------------------------------------------------------------
// jcs_scanner
// Mode register plus the per-byte decode that yields up to two results.
// ----------------------------------------------------------------------------
module jcs_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [7:0]         in_char,
  input  logic               in_last_in,
  output jcs_pkg::scan_res_t res
);
  import jcs_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_SLASH  = 3'd1,
    M_LINE   = 3'd2,
    M_BLOCK  = 3'd3,
    M_STAR   = 3'd4,
    M_STRING = 3'd5,
    M_ESCAPE = 3'd6
  } mode_t;

  mode_t      mode_r, mode_nxt, mode_scan;
  logic [1:0] n;
  logic [7:0] b0, b1;

  always_comb begin
    mode_scan = mode_r;
    n         = 2'd0;
    b0        = 8'h00;
    b1        = 8'h00;
    unique case (mode_r)
      M_SLASH: begin
        if (in_char == CH_SLASH) begin
          mode_scan = M_LINE;
        end else if (in_char == CH_STAR) begin
          mode_scan = M_BLOCK;
        end else begin
          // held slash was plain text: release it with this byte
          n         = 2'd2;
          b0        = CH_SLASH;
          b1        = in_char;
          mode_scan = (in_char == CH_QUOTE) ? M_STRING : M_NORMAL;
        end
      end
      M_LINE: begin
        if (in_char == CH_NEWLINE) begin
          n         = 2'd1;
          b0        = in_char;
          mode_scan = M_NORMAL;
        end
      end
      M_BLOCK: begin
        if (in_char == CH_STAR) mode_scan = M_STAR;
      end
      M_STAR: begin
        if (in_char == CH_SLASH)     mode_scan = M_NORMAL;
        else if (in_char != CH_STAR) mode_scan = M_BLOCK;
      end
      M_STRING: begin
        n  = 2'd1;
        b0 = in_char;
        if (in_char == CH_BACKSLASH)  mode_scan = M_ESCAPE;
        else if (in_char == CH_QUOTE) mode_scan = M_NORMAL;
      end
      M_ESCAPE: begin
        n         = 2'd1;
        b0        = in_char;
        mode_scan = M_STRING;
      end
      default: begin
        if (in_char == CH_SLASH) begin
          mode_scan = M_SLASH;
        end else begin
          n         = 2'd1;
          b0        = in_char;
          mode_scan = (in_char == CH_QUOTE) ? M_STRING : M_NORMAL;
        end
      end
    endcase

    // end of stream: flush a held slash, fall back to normal
    mode_nxt = mode_scan;
    if (in_last_in) begin
      if (mode_scan == M_SLASH) begin
        n  = 2'd1;
        b0 = CH_SLASH;
      end
      mode_nxt = M_NORMAL;
    end
  end

  always_comb begin
    res.n  = n;
    res.e0 = '{out_char: b0, has_char: 1'b1, run_last: (n == 2'd1),
               stream_end: in_last_in && (n == 2'd1)};
    res.e1 = '{out_char: b1, has_char: 1'b1, run_last: 1'b1,
               stream_end: in_last_in};
    if (n == 2'd0 && in_last_in) begin
      // marker-only result so the stream end is still seen
      res.n  = 2'd1;
      res.e0 = '{out_char: 8'h00, has_char: 1'b0, run_last: 1'b1, stream_end: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
    end else if (adv) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ===== design/jcs_outq.sv =====
// ----------------------------------------------------------------------------
// jcs_outq
// Small result queue: takes up to two entries per cycle, gives one.
// ----------------------------------------------------------------------------
module jcs_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jcs_pkg::scan_res_t res,
  input  logic               pop,
  output logic               room,
  output logic               nonempty,
  output jcs_pkg::out_ent_t  head
);
  import jcs_pkg::*;

  out_ent_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [Q_AW:0]      cnt_r, cnt_nxt;
  logic [1:0]         n_push;
  logic [Q_AW-1:0]    wr_ptr_p1;

  assign n_push    = push ? res.n : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign room      = cnt_r <= (Q_AW+1)'(Q_DEPTH - 2);
  assign nonempty  = cnt_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    cnt_nxt    = cnt_r + (Q_AW+1)'(n_push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_ptr_r]  <= res.e0;
    if (n_push == 2'd2) mem_r[wr_ptr_p1] <= res.e1;
  end

endmodule

// ===== design/json_comment_stripper.sv =====
// ----------------------------------------------------------------------------
// json_comment_stripper
// Removes // and /* */ comments from a byte stream, outside quoted strings.
// ----------------------------------------------------------------------------
// One byte is taken per request and decoded in the same cycle against a 3-bit
// mode register; the results it releases (zero, one or two) go into a
// four-entry result queue and leave one per cycle while out_stall is low.
// A byte is accepted every cycle as long as the queue has room for two
// entries, so a steady stream runs at one byte per cycle; only a held slash
// released together with the byte after it puts two results in the queue at
// once, and in_stall rises only when the consumer falls behind. A slash
// outside strings and comments is held until the next byte shows whether it
// opens a comment. in_last_in marks the final byte: a held slash is flushed,
// the mode returns to normal, and the last result of that byte carries
// out_stream_end (a result with out_has_char low is a marker only, sent when
// the final byte releases nothing).
// ----------------------------------------------------------------------------
module json_comment_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_has_char,
  output logic       out_run_last,
  output logic       out_stream_end
);
  import jcs_pkg::*;

  scan_res_t res;
  out_ent_t  head;
  logic      room, nonempty, adv, pop;

  // a request is taken when valid and the queue can absorb two results
  assign in_stall = !room;
  assign adv      = in_valid && room;
  assign pop      = nonempty && !out_stall;

  jcs_scanner u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_char    (in_char),
    .in_last_in (in_last_in),
    .res        (res)
  );

  jcs_outq u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (adv),
    .res      (res),
    .pop      (pop),
    .room     (room),
    .nonempty (nonempty),
    .head     (head)
  );

  assign out_valid      = nonempty;
  assign out_char       = head.out_char;
  assign out_has_char   = head.has_char;
  assign out_run_last   = head.run_last;
  assign out_stream_end = head.stream_end;

endmodule

// ===== test/json_comment_stripper_checker.sv =====
// ----------------------------------------------------------------------------
// json_comment_stripper_checker
// Watches both request channels, predicts the cleaned stream, compares.
// ----------------------------------------------------------------------------
module json_comment_stripper_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_has_char,
  input  logic       out_run_last,
  input  logic       out_stream_end,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import jcs_pkg::*;

  typedef enum logic [2:0] {
    SCAN_TEXT, SCAN_SLASH, SCAN_LINE, SCAN_BLOCK, SCAN_STAR, SCAN_STRING, SCAN_ESCAPE
  } scan_mode_t;

  scan_mode_t mode_q;
  out_ent_t   cleaned_q[$];
  int         err_cnt;

  initial begin
    errors  = 0;
    pending = 0;
    err_cnt = 0;
    mode_q  = SCAN_TEXT;
  end

  function automatic void flag_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
  endfunction

  // Strip one byte: work out the bytes it releases and queue them.
  task automatic strip_byte(input logic [7:0] c, input logic lst);
    logic [7:0] rel [0:1];
    int         n;
    logic       as_text;
    out_ent_t   ent;
    n       = 0;
    as_text = 1'b0;
    case (mode_q)
      SCAN_SLASH: begin
        if (c == CH_SLASH) begin
          mode_q = SCAN_LINE;
        end else if (c == CH_STAR) begin
          mode_q = SCAN_BLOCK;
        end else begin
          rel[n]  = CH_SLASH;
          n++;
          as_text = 1'b1;
        end
      end
      SCAN_LINE: begin
        if (c == CH_NEWLINE) begin
          rel[n] = c;
          n++;
          mode_q = SCAN_TEXT;
        end
      end
      SCAN_BLOCK: if (c == CH_STAR) mode_q = SCAN_STAR;
      SCAN_STAR: begin
        if (c == CH_SLASH) mode_q = SCAN_TEXT;
        else if (c != CH_STAR) mode_q = SCAN_BLOCK;
      end
      SCAN_STRING: begin
        rel[n] = c;
        n++;
        if (c == CH_BACKSLASH) mode_q = SCAN_ESCAPE;
        else if (c == CH_QUOTE) mode_q = SCAN_TEXT;
      end
      SCAN_ESCAPE: begin
        rel[n] = c;
        n++;
        mode_q = SCAN_STRING;
      end
      default: as_text = 1'b1;
    endcase
    if (as_text) begin
      if (c == CH_SLASH) begin
        mode_q = SCAN_SLASH;
      end else begin
        mode_q = (c == CH_QUOTE) ? SCAN_STRING : SCAN_TEXT;
        rel[n] = c;
        n++;
      end
    end
    if (lst) begin
      if (mode_q == SCAN_SLASH) begin
        rel[n] = CH_SLASH;
        n++;
      end
      mode_q = SCAN_TEXT;
    end
    for (int k = 0; k < n; k++) begin
      ent.out_char   = rel[k];
      ent.has_char   = 1'b1;
      ent.run_last   = (k == n - 1);
      ent.stream_end = lst && (k == n - 1);
      cleaned_q.insert(cleaned_q.size(), ent);
    end
    // final byte that releases nothing still marks the stream end
    if (n == 0 && lst) begin
      ent = '{out_char: 8'h00, has_char: 1'b0, run_last: 1'b1, stream_end: 1'b1};
      cleaned_q.insert(cleaned_q.size(), ent);
    end
  endtask

  always @(posedge clk) begin
    out_ent_t want;
    if (!rst_n) begin
      mode_q = SCAN_TEXT;
      cleaned_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cleaned_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got char %h has %b",
                   $time, out_char, out_has_char);
        end else begin
          want = cleaned_q.pop_front();
          if (out_char !== want.out_char) flag_field("out_char", want.out_char, out_char);
          if (out_has_char !== want.has_char)
            flag_field("out_has_char", want.has_char, out_has_char);
          if (out_run_last !== want.run_last)
            flag_field("out_run_last", want.run_last, out_run_last);
          if (out_stream_end !== want.stream_end)
            flag_field("out_stream_end", want.stream_end, out_stream_end);
        end
      end
      // results are registered before output, so prediction after the check is safe
      if (in_valid && !in_stall) strip_byte(in_char, in_last_in);
    end
    errors  <= err_cnt;
    pending <= cleaned_q.size();
  end

endmodule

// ===== test/json_comment_stripper_tb.sv =====
// ----------------------------------------------------------------------------
// json_comment_stripper_tb
// Drives directed and random source text through the comment stripper.
// ----------------------------------------------------------------------------
// A short directed run hits byte extremes, line and block comments, strings
// with escapes, and stream ends on a held slash, in a block comment and in a
// string escape. Random text follows, built mostly from well-formed tokens
// (strings, comments, plain runs) with noise and broken fragments mixed in.
// The sender works in bursts, the consumer stalls on its own changing
// pattern, once holds off long enough to back the block up, and once the
// sender waits for a drain. The checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module json_comment_stripper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jcs_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 60;    // long consumer hold-off
  localparam int IDLE_LIMIT   = 1000;  // cycles without any request moving
  localparam int DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       in_last_in = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_has_char;
  logic       out_run_last;
  logic       out_stream_end;

  int   mismatches;
  int   pending_results;
  int   bytes_sent = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  logic hold_tog = 1'b0;  // toggled to ask the consumer for a long hold-off
  logic [7:0] tok[$];     // bytes of the token being built

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  json_comment_stripper uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char       (in_char),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_has_char  (out_has_char),
    .out_run_last  (out_run_last),
    .out_stream_end(out_stream_end)
  );

  json_comment_stripper_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char       (in_char),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_has_char  (out_has_char),
    .out_run_last  (out_run_last),
    .out_stream_end(out_stream_end),
    .errors        (mismatches),
    .pending       (pending_results)
  );

  // Append one byte to the token under construction.
  function automatic void tok_add(input logic [7:0] v);
    tok.insert(tok.size(), v);
  endfunction

  // Offer one byte and hold it until taken. Called right after a rising edge.
  // Valid drops only at the end of a burst, so a back-to-back request never
  // sees valid lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] c, input logic lst);
    int gap;
    in_valid   <= 1'b1;
    in_char    <= c;
    in_last_in <= lst;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // mostly short bursts, sometimes a long unbroken stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Consumer: stall pattern changes style at random intervals; a toggle of
  // hold_tog starts a long hold-off counted here.
  initial begin : consumer
    int   style;
    int   style_left;
    int   hold_left;
    logic hold_seen;
    style      = 0;
    style_left = 0;
    hold_left  = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(20, 120);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= style_left[1];
        endcase
      end
    end
  end

  // Watchdog on cycles in which no request moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("json_comment_stripper_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] b;
    logic       lst;
    int         kind;
    int         len;
    int         token_idx;
    token_idx = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("/x", 1'b0);            // held slash released with next byte
    send_text("//z\n", 1'b0);         // line comment keeps its newline
    send_text("/**a*/", 1'b0);        // star run, star then other, close
    send_text("\"/\\\"\"", 1'b0);     // slash and escaped quote inside string
    send_text("/", 1'b1);             // held slash flushed at stream end
    send_text("/*", 1'b1);            // stream ends inside a comment: marker only
    send_text("\"\\", 1'b1);          // trailing backslash in a string
    drain();

    // ---- random tokens ----
    while (bytes_sent < RANDOM_ITEMS + 24) begin
      tok.delete();
      kind = $urandom_range(0, 15);
      len  = $urandom_range(0, 8);
      case (kind)
        0, 1, 2, 3: begin  // plain text run
          for (int i = 0; i <= len % 6; i++) tok_add(8'($urandom_range(8'h61, 8'h7A)));
        end
        4, 5: begin  // string with escapes
          tok_add(CH_QUOTE);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
              tok_add(CH_BACKSLASH);
              tok_add(8'($urandom_range(0, 255)));
            end else begin
              b = 8'($urandom_range(8'h20, 8'h7E));
              tok_add((b == CH_QUOTE || b == CH_BACKSLASH) ? 8'h71 : b);
            end
          end
          tok_add(CH_QUOTE);
        end
        6, 7: begin  // line comment
          tok_add(CH_SLASH);
          tok_add(CH_SLASH);
          for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            tok_add((b == CH_NEWLINE) ? 8'h78 : b);
          end
          tok_add(CH_NEWLINE);
        end
        8, 9: begin  // block comment, stars favored inside
          tok_add(CH_SLASH);
          tok_add(CH_STAR);
          for (int i = 0; i < len; i++)
            tok_add(($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(0, 255)));
          tok_add(CH_STAR);
          tok_add(CH_SLASH);
        end
        10: tok_add(CH_SLASH);  // lone slash
        11: begin  // broken fragment: unmatched opener or closer
          tok_add(($urandom_range(0, 1) == 0) ? CH_SLASH : CH_STAR);
          tok_add(($urandom_range(0, 1) == 0) ? CH_SLASH : CH_STAR);
        end
        default: begin  // full-range noise
          for (int i = 0; i <= len % 3; i++) tok_add(8'($urandom_range(0, 255)));
        end
      endcase
      lst = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < tok.size(); i++)
        send_byte(tok[i], lst && (i == tok.size() - 1));

      token_idx++;
      if (token_idx == 30) begin
        // consumer holds off while the sender keeps pushing: queue fills up
        hold_tog   <= ~hold_tog;
        burst_left = 80;
      end
      if (token_idx == 70) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("json_comment_stripper_tb OK");
    end else begin
      $display("json_comment_stripper_tb NOT OK");
    end
    $finish;
  end

endmodule
